// ===== rtl/core/clle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types and constants for the cursor linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int VALUE_W      = 64;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int M_TDATA_W    = 72;  // 64 + 2 + 1 = 67, padded to whole bytes

    typedef enum logic [KIND_W-1:0] {
        KIND_ADVANCE = 3'd0,
        KIND_INSERT  = 3'd1,
        KIND_DELETE  = 3'd2,
        KIND_READ    = 3'd3,
        KIND_WRITE   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR,
        S_HAS,
        S_DATA,
        S_FREE,
        S_FREE2,
        S_INS1,
        S_INS2,
        S_NEXT,
        S_DEL2,
        S_DEL3
    } state_t;

    // Link memory port controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } link_cmd_t;

endpackage

// ===== rtl/core/clle_link_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clle_link_store
// Link memory with registered read and a post-reset init sweep.
// ----------------------------------------------------------------------------
module clle_link_store #(
    parameter int CAPACITY = clle_pkg::CAPACITY_DEF
) (
    clk,
    rst_n,
    cmd,
    raddr,
    waddr,
    wdata,
    rdata,
    ready
);
    import clle_pkg::*;

    localparam int NODES  = CAPACITY + 2;
    localparam int LINK_W = $clog2(NODES);
    localparam logic [LINK_W-1:0] LAST_NODE = LINK_W'(NODES - 1);

    input  logic              clk;
    input  logic              rst_n;
    input  link_cmd_t         cmd;
    input  logic [LINK_W-1:0] raddr;
    input  logic [LINK_W-1:0] waddr;
    input  logic [LINK_W-1:0] wdata;
    output logic [LINK_W-1:0] rdata;
    output logic              ready;

    logic [LINK_W-1:0] link_mem [NODES];
    logic [LINK_W-1:0] rdata_reg;

    logic              init_busy_reg;
    logic              init_busy_next;
    logic [LINK_W-1:0] init_idx_reg;
    logic [LINK_W-1:0] init_idx_next;
    logic [LINK_W-1:0] init_val;

    logic              mem_we;
    logic [LINK_W-1:0] mem_waddr;
    logic [LINK_W-1:0] mem_wdata;

    // used list: 0 -> 0; free chain: 1 -> 2 -> ... -> last -> 1
    always_comb
    begin
        priority if (init_idx_reg == '0)
        begin
            init_val = '0;
        end
        else if (init_idx_reg == LAST_NODE)
        begin
            init_val = LINK_W'(1);
        end
        else
        begin
            init_val = init_idx_reg + LINK_W'(1);
        end
    end

    always_comb
    begin
        init_busy_next = init_busy_reg;
        init_idx_next  = init_idx_reg;
        if (init_busy_reg)
        begin
            init_idx_next = init_idx_reg + LINK_W'(1);
            if (init_idx_reg == LAST_NODE)
            begin
                init_busy_next = 1'b0;
                init_idx_next  = init_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_idx_reg  <= '0;
        end
        else
        begin
            init_busy_reg <= init_busy_next;
            init_idx_reg  <= init_idx_next;
        end
    end

    assign mem_we    = init_busy_reg | cmd.wr_en;
    assign mem_waddr = init_busy_reg ? init_idx_reg : waddr;
    assign mem_wdata = init_busy_reg ? init_val : wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= link_mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign ready = ~init_busy_reg;

endmodule

// ===== rtl/core/cursor_linked_list_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// Fixed-capacity singly linked list with a cursor and a free list.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one operation per item: s_tuser carries the kind
//   (advance, insert, delete, read, write), s_tdata the 64-bit value.
//   Master stream returns exactly one result item per operation:
//   read value, status and a has-current flag.
//   Items are handled one at a time; each operation is a chain of dependent
//   reads and writes of the link memory (one read port, one write port,
//   registered read). s_tready rises again right after the result is
//   loaded into the output register, so a new item is taken while the
//   previous result still waits on the master side.
//   After reset the link memory is swept once to build the empty list and
//   the free chain, writing all CAPACITY+2 nodes (258 by default) while
//   s_tready is low.
//   When the receiver stalls, one further result is parked in a skid
//   register and s_tready stays low until it moves on.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core #(
    parameter int CAPACITY = clle_pkg::CAPACITY_DEF
) (
    clk,
    rst_n,
    s_tvalid,
    s_tready,
    s_tdata,
    s_tuser,
    m_tvalid,
    m_tready,
    m_tdata
);
    import clle_pkg::*;

    localparam int NODES  = CAPACITY + 2;
    localparam int LINK_W = $clog2(NODES);
    localparam logic [LINK_W-1:0] NODE_HEAD = LINK_W'(0);
    localparam logic [LINK_W-1:0] NODE_FREE = LINK_W'(1);

    input  logic                            clk;
    input  logic                            rst_n;
    input  logic                            s_tvalid;
    output logic                            s_tready;
    input  logic [clle_pkg::VALUE_W-1:0]    s_tdata;   // [63:0] value
    input  logic [clle_pkg::KIND_W-1:0]     s_tuser;   // [2:0] kind
    output logic                            m_tvalid;
    input  logic                            m_tready;
    output logic [clle_pkg::M_TDATA_W-1:0]  m_tdata;   // [63:0] read_value,
                                                        // [65:64] status,
                                                        // [66] has_current, rest 0

    // ---------------- control state ----------------
    state_t               state_reg, state_next;
    kind_t                kind_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [LINK_W-1:0]    cursor_reg, cursor_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;     // link of cursor (current element)
    logic [LINK_W-1:0]    node_reg, node_next;   // node taken from the free list
    logic [LINK_W-1:0]    nxt_reg, nxt_next;     // successor of a deleted node

    // ---------------- link memory ----------------
    link_cmd_t            link_cmd;
    logic [LINK_W-1:0]    link_raddr;
    logic [LINK_W-1:0]    link_waddr;
    logic [LINK_W-1:0]    link_wdata;
    logic [LINK_W-1:0]    link_rdata;
    logic                 link_ready;

    // ---------------- data memory (single port) ----------------
    logic [VALUE_W-1:0]   data_mem [NODES];
    logic [VALUE_W-1:0]   data_rdata_reg;
    logic                 data_ren;
    logic                 data_wen;
    logic [LINK_W-1:0]    data_addr;

    // ---------------- result path ----------------
    logic                 fin;
    logic [VALUE_W-1:0]   fin_rd;
    status_t              fin_st;
    logic                 fin_hc;

    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_rd_reg;
    status_t              out_st_reg;
    logic                 out_hc_reg;

    logic                 pend_reg;
    logic [VALUE_W-1:0]   pend_rd_reg;
    status_t              pend_st_reg;
    logic                 pend_hc_reg;

    logic                 slot_free;
    logic                 accept;

    clle_link_store #(
        .CAPACITY (CAPACITY)
    ) u_link (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (link_cmd),
        .raddr (link_raddr),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .rdata (link_rdata),
        .ready (link_ready)
    );

    assign s_tready  = (state_reg == S_IDLE) && !pend_reg && link_ready;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    // Sequencer: each state issues at most one link read and one link write.
    always_comb
    begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        cur_next     = cur_reg;
        node_next    = node_reg;
        nxt_next     = nxt_reg;
        link_cmd     = '0;
        link_raddr   = cursor_reg;
        link_waddr   = NODE_HEAD;
        link_wdata   = NODE_HEAD;
        data_ren     = 1'b0;
        data_wen     = 1'b0;
        data_addr    = cur_reg;
        fin          = 1'b0;
        fin_rd       = '0;
        fin_st       = ST_OK;
        fin_hc       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    link_cmd.rd_en = 1'b1;
                    link_raddr     = cursor_reg;
                    state_next     = S_CUR;
                end
            end

            S_CUR:
            begin
                cur_next = link_rdata;
                unique case (kind_reg)
                    KIND_ADVANCE:
                    begin
                        cursor_next    = link_rdata;
                        link_cmd.rd_en = 1'b1;
                        link_raddr     = link_rdata;
                        state_next     = S_HAS;
                    end
                    KIND_INSERT:
                    begin
                        link_cmd.rd_en = 1'b1;
                        link_raddr     = NODE_FREE;
                        state_next     = S_FREE;
                    end
                    KIND_DELETE:
                    begin
                        if (link_rdata == NODE_HEAD)
                        begin
                            fin        = 1'b1;
                            fin_st     = ST_NONE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            link_cmd.rd_en = 1'b1;
                            link_raddr     = link_rdata;
                            state_next     = S_NEXT;
                        end
                    end
                    KIND_READ:
                    begin
                        if (link_rdata == NODE_HEAD)
                        begin
                            fin        = 1'b1;
                            fin_st     = ST_NONE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            data_ren   = 1'b1;
                            data_addr  = link_rdata;
                            state_next = S_DATA;
                        end
                    end
                    KIND_WRITE:
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                        if (link_rdata == NODE_HEAD)
                        begin
                            fin_st = ST_NONE;
                        end
                        else
                        begin
                            data_wen  = 1'b1;
                            data_addr = link_rdata;
                            fin_hc    = 1'b1;
                        end
                    end
                    default:
                    begin
                        // unused kinds: no change, report current presence
                        fin        = 1'b1;
                        fin_hc     = (link_rdata != NODE_HEAD);
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_HAS:
            begin
                fin        = 1'b1;
                fin_hc     = (link_rdata != NODE_HEAD);
                state_next = S_IDLE;
            end

            S_DATA:
            begin
                fin        = 1'b1;
                fin_rd     = data_rdata_reg;
                fin_hc     = 1'b1;
                state_next = S_IDLE;
            end

            S_FREE:
            begin
                node_next = link_rdata;
                if (link_rdata == NODE_FREE)
                begin
                    // free list empty
                    fin        = 1'b1;
                    fin_st     = ST_FULL;
                    fin_hc     = (cur_reg != NODE_HEAD);
                    state_next = S_IDLE;
                end
                else
                begin
                    link_cmd.rd_en = 1'b1;
                    link_raddr     = link_rdata;
                    state_next     = S_FREE2;
                end
            end

            S_FREE2:
            begin
                // unlink node from free list, store its value
                link_cmd.wr_en = 1'b1;
                link_waddr     = NODE_FREE;
                link_wdata     = link_rdata;
                data_wen       = 1'b1;
                data_addr      = node_reg;
                state_next     = S_INS1;
            end

            S_INS1:
            begin
                link_cmd.wr_en = 1'b1;
                link_waddr     = node_reg;
                link_wdata     = cur_reg;
                state_next     = S_INS2;
            end

            S_INS2:
            begin
                link_cmd.wr_en = 1'b1;
                link_waddr     = cursor_reg;
                link_wdata     = node_reg;
                fin            = 1'b1;
                fin_hc         = 1'b1;
                state_next     = S_IDLE;
            end

            S_NEXT:
            begin
                // bypass the current element, fetch free head
                nxt_next       = link_rdata;
                link_cmd.wr_en = 1'b1;
                link_waddr     = cursor_reg;
                link_wdata     = link_rdata;
                link_cmd.rd_en = 1'b1;
                link_raddr     = NODE_FREE;
                state_next     = S_DEL2;
            end

            S_DEL2:
            begin
                link_cmd.wr_en = 1'b1;
                link_waddr     = cur_reg;
                link_wdata     = link_rdata;
                state_next     = S_DEL3;
            end

            S_DEL3:
            begin
                link_cmd.wr_en = 1'b1;
                link_waddr     = NODE_FREE;
                link_wdata     = cur_reg;
                fin            = 1'b1;
                fin_hc         = (nxt_reg != NODE_HEAD);
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(s_tuser);
            value_reg <= s_tdata;
        end
        cur_reg  <= cur_next;
        node_reg <= node_next;
        nxt_reg  <= nxt_next;
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (data_wen)
        begin
            data_mem[data_addr] <= value_reg;
        end
        if (data_ren)
        begin
            data_rdata_reg <= data_mem[data_addr];
        end
    end

    // output register with one-deep skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            priority if (fin && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (fin)
            begin
                pend_reg <= 1'b1;
            end
            else if (pend_reg && slot_free)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (fin && slot_free)
        begin
            out_rd_reg <= fin_rd;
            out_st_reg <= fin_st;
            out_hc_reg <= fin_hc;
        end
        else if (fin)
        begin
            pend_rd_reg <= fin_rd;
            pend_st_reg <= fin_st;
            pend_hc_reg <= fin_hc;
        end
        else if (pend_reg && slot_free)
        begin
            out_rd_reg <= pend_rd_reg;
            out_st_reg <= pend_st_reg;
            out_hc_reg <= pend_hc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - VALUE_W - STATUS_W - 1)'(0),
                       out_hc_reg, out_st_reg, out_rd_reg};

endmodule
